@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a single clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define DDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked at every rising edge, reset included.
`define DDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ src/dds_pkg.sv @@
// ----------------------------------------------------------------------------
// Degree-day snowmelt package
// Sizes, codes and word types shared by the snowmelt modules.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int CELL_COUNT = 4096;
   localparam int CELL_BITS  = $clog2(CELL_COUNT);
   localparam int DATA_W     = 24;

   localparam logic [DATA_W-1:0] DATA_MAX     = '1;
   localparam logic [16:0]       FRACTION_ONE = 17'h10000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SNOW_FRACTION        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MELT_FACTOR_TEMP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MELT_FACTOR_RAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MELT_TEMPERATURE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SNOWFALL_TEMPERATURE = 3'd4;

   localparam logic [1:0] KIND_COLD = 2'd0;
   localparam logic [1:0] KIND_SNOW = 2'd1;
   localparam logic [1:0] KIND_MELT = 2'd2;

   localparam int LINK_DEPTH = 2;
   localparam int LINK_PTR_W = $clog2(LINK_DEPTH);
   localparam int LINK_CNT_W = $clog2(LINK_DEPTH + 1);

   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [11:0]        cell_index;
      logic signed [15:0] air_temperature;
      logic [15:0]        precipitation;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] melt_amount;
      logic [DATA_W-1:0] snow_stored;
      logic [DATA_W-1:0] water_out;
   } rsp_type;

   // Classified word handed from the front end to the store update.
   typedef struct packed {
      logic [CELL_BITS-1:0] cell_addr;
      logic [1:0]           kind;
      logic [15:0]          precip;
      logic [15:0]          snow;
      logic [DATA_W-1:0]    term_temp;
      logic [31:0]          rain_prod;
      logic [15:0]          delta;
   } link_type;

endpackage

@@ src/dds_link_queue.sv @@
// ----------------------------------------------------------------------------
// Snowmelt link queue
// Short queue of classified words between the front end and the store update.
// ----------------------------------------------------------------------------
module dds_link_queue import dds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  link_type push_data,
   input  logic     pop,
   output logic     empty,
   output link_type head
);

   link_type                slot_ff [LINK_DEPTH];
   logic [LINK_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [LINK_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LINK_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == LINK_CNT_W'(LINK_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LINK_PTR_W'(LINK_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LINK_PTR_W'(LINK_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/dds_front.sv @@
// ----------------------------------------------------------------------------
// Snowmelt front end
// Holds the settings, takes input words and sorts each into snowfall, melt or
// cold, with the products that do not depend on the stored snow.
// ----------------------------------------------------------------------------
module dds_front import dds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear_busy,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   link_push,
   output link_type               link_data,
   input  logic                   link_full
);

   logic [16:0]        snow_fraction_ff, snow_fraction_in;
   logic [15:0]        melt_factor_temp_ff, melt_factor_temp_in;
   logic [15:0]        melt_factor_rain_ff, melt_factor_rain_in;
   logic signed [15:0] melt_temperature_ff, melt_temperature_in;
   logic signed [15:0] snowfall_temperature_ff, snowfall_temperature_in;

   logic    stage_valid_ff, stage_valid_in;
   req_type stage_ff, stage_in;
   logic    accept;

   logic [16:0] delta;
   logic        is_snow;
   logic [16:0] fraction;
   logic [32:0] snow_prod;
   logic [31:0] temp_prod;
   logic [31:0] rain_prod;

   always_comb begin
      snow_fraction_in        = snow_fraction_ff;
      melt_factor_temp_in     = melt_factor_temp_ff;
      melt_factor_rain_in     = melt_factor_rain_ff;
      melt_temperature_in     = melt_temperature_ff;
      snowfall_temperature_in = snowfall_temperature_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SNOW_FRACTION:        snow_fraction_in        = csr_data;
            CSR_MELT_FACTOR_TEMP:     melt_factor_temp_in     = csr_data[15:0];
            CSR_MELT_FACTOR_RAIN:     melt_factor_rain_in     = csr_data[15:0];
            CSR_MELT_TEMPERATURE:     melt_temperature_in     = $signed(csr_data[15:0]);
            CSR_SNOWFALL_TEMPERATURE: snowfall_temperature_in = $signed(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   assign req_full       = clear_busy | (stage_valid_ff & link_full);
   assign accept         = req_push & ~req_full;
   assign link_push      = stage_valid_ff & ~link_full;
   assign stage_valid_in = accept | (stage_valid_ff & ~link_push);
   assign stage_in       = accept ? req_data : stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         snow_fraction_ff        <= '0;
         melt_factor_temp_ff     <= '0;
         melt_factor_rain_ff     <= '0;
         melt_temperature_ff     <= '0;
         snowfall_temperature_ff <= '0;
         stage_valid_ff          <= 1'b0;
      end else begin
         snow_fraction_ff        <= snow_fraction_in;
         melt_factor_temp_ff     <= melt_factor_temp_in;
         melt_factor_rain_ff     <= melt_factor_rain_in;
         melt_temperature_ff     <= melt_temperature_in;
         snowfall_temperature_ff <= snowfall_temperature_in;
         stage_valid_ff          <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // The temperature difference needs 17 bits; when it is not negative its
   // low 16 bits hold the whole value.
   assign delta = {stage_ff.air_temperature[15], stage_ff.air_temperature}
                - {melt_temperature_ff[15], melt_temperature_ff};
   assign is_snow  = $signed(stage_ff.air_temperature) < snowfall_temperature_ff;
   assign fraction = (snow_fraction_ff > FRACTION_ONE) ? FRACTION_ONE : snow_fraction_ff;

   assign snow_prod = 33'(fraction) * 33'(stage_ff.precipitation);
   assign temp_prod = 32'(melt_factor_temp_ff) * 32'(delta[15:0]);
   assign rain_prod = 32'(melt_factor_rain_ff) * 32'(stage_ff.precipitation);

   always_comb begin
      link_data.cell_addr = stage_ff.cell_index[CELL_BITS-1:0];
      if (is_snow) begin
         link_data.kind = KIND_SNOW;
      end else if (delta[16]) begin
         link_data.kind = KIND_COLD;
      end else begin
         link_data.kind = KIND_MELT;
      end
      link_data.precip    = stage_ff.precipitation;
      // The snow part never exceeds the precipitation, so 16 bits suffice.
      link_data.snow      = snow_prod[31:16];
      link_data.term_temp = temp_prod[31:8];
      link_data.rain_prod = rain_prod;
      link_data.delta     = delta[15:0];
   end

endmodule

@@ src/dds_back.sv @@
// ----------------------------------------------------------------------------
// Snowmelt store update
// Reads the cell's snow store, applies any snowfall or melt, writes it back and
// queues the result word. Clears the store after reset.
// ----------------------------------------------------------------------------
module dds_back import dds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   output logic     clear_busy,
   input  logic     link_empty,
   input  link_type link_data,
   output logic     link_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic                 state_ff, state_in;
   logic                 clearing_ff, clearing_in;
   logic [CELL_BITS-1:0] clear_addr_ff, clear_addr_in;
   link_type             work_ff;
   logic [DATA_W-1:0]    rain_ff;
   logic [DATA_W-1:0]    rd_data_ff;

   logic [DATA_W-1:0]    store_mem [CELL_COUNT];
   logic                 mem_we;
   logic [CELL_BITS-1:0] mem_addr;
   logic [DATA_W-1:0]    mem_wdata;

   rsp_type              out_slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_count_ff, out_count_in;
   logic                 out_push, out_pop;

   logic                 start;
   logic [47:0]          rain_full;
   rsp_type              result;

   assign clear_busy = clearing_ff;
   assign start      = (state_ff == ST_IDLE) & ~clearing_ff & ~link_empty
                     & (out_count_ff < OUT_CNT_W'(OUT_DEPTH));
   assign link_pop   = start;
   assign rain_full  = 48'(link_data.rain_prod) * 48'(link_data.delta);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_CALC;
         ST_CALC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign clearing_in   = clearing_ff & (clear_addr_ff != CELL_BITS'(CELL_COUNT - 1));
   assign clear_addr_in = clearing_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= link_data;
         rain_ff <= rain_full[47:24];
      end
   end

   // An empty store with no precipitation falls out of every branch below as
   // all-zero fields, so it needs no case of its own.
   always_comb begin
      logic [DATA_W:0]   sum;
      logic [DATA_W:0]   melt_sum;
      logic [DATA_W:0]   water_sum;
      logic [DATA_W-1:0] store;
      logic [DATA_W-1:0] melt;
      sum       = '0;
      melt_sum  = '0;
      water_sum = '0;
      store     = rd_data_ff;
      melt      = '0;
      result.melt_amount = '0;
      result.snow_stored = store;
      result.water_out   = DATA_W'(work_ff.precip);
      case (work_ff.kind)
         KIND_SNOW: begin
            sum = {1'b0, store} + (DATA_W + 1)'(work_ff.snow);
            result.snow_stored = sum[DATA_W] ? DATA_MAX : sum[DATA_W-1:0];
            result.water_out   = DATA_W'(work_ff.precip - work_ff.snow);
         end
         KIND_MELT: begin
            melt_sum = {1'b0, work_ff.term_temp} + {1'b0, rain_ff};
            melt     = (melt_sum > {1'b0, store}) ? store : melt_sum[DATA_W-1:0];
            water_sum = (DATA_W + 1)'(work_ff.precip) + {1'b0, melt};
            result.melt_amount = melt;
            result.snow_stored = store - melt;
            result.water_out   = water_sum[DATA_W] ? DATA_MAX : water_sum[DATA_W-1:0];
         end
         default: ;
      endcase
   end

   assign mem_we    = clearing_ff | (state_ff == ST_CALC);
   assign mem_addr  = clearing_ff ? clear_addr_ff : work_ff.cell_addr;
   assign mem_wdata = clearing_ff ? '0 : result.snow_stored;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (start) begin
         rd_data_ff <= store_mem[link_data.cell_addr];
      end
   end

   assign out_push  = (state_ff == ST_CALC);
   assign out_pop   = rsp_pop & ~rsp_empty;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_slot_ff[out_rd_ff];

   always_comb begin
      out_wr_in    = out_wr_ff;
      out_rd_in    = out_rd_ff;
      out_count_in = out_count_ff;
      if (out_push) begin
         out_wr_in = (out_wr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
      end
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_slot_ff[out_wr_ff] <= result;
      end
   end

endmodule

@@ src/degree_day_snowmelt.sv @@
// ----------------------------------------------------------------------------
// Degree-day snowmelt
// Path: a word passes the front stage register, the link queue and the work
// register of the store update, which takes a new word only after the read and
// then the write of the single-port snow store for the last one.
// Reset: synchronous; the store is then cleared cell by cell while full is high.
// ----------------------------------------------------------------------------
module degree_day_snowmelt import dds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic     clear_busy;
   logic     link_push, link_full, link_pop, link_empty;
   link_type link_in, link_head;

   dds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .link_push  (link_push),
      .link_data  (link_in),
      .link_full  (link_full)
   );

   dds_link_queue u_link (
      .clock     (clock),
      .reset     (reset),
      .push      (link_push),
      .full      (link_full),
      .push_data (link_in),
      .pop       (link_pop),
      .empty     (link_empty),
      .head      (link_head)
   );

   dds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .link_empty (link_empty),
      .link_data  (link_head),
      .link_pop   (link_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ src/dds_checker.sv @@
// ----------------------------------------------------------------------------
// Degree-day snowmelt checker
// Port-level assertions on the snowmelt block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_checker import dds_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // The store is being cleared right after reset, so no word may enter.
   `DDS_ASSERT_ALWAYS(a_full_after_reset, clock, reset |=> req_full, "full low after reset")

   `DDS_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> rsp_empty, "result after reset")

   `DDS_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)),
      "waiting result word changed")

   // Melt is always passed on with the water, so water covers the melt.
   `DDS_ASSERT(a_water_covers_melt, clock, reset,
      !rsp_empty |-> (rsp_data.water_out >= rsp_data.melt_amount),
      "water below melt")

endmodule

bind degree_day_snowmelt dds_checker u_dds_checker (.*);
